/* rtl/core/cursor_doubly_linked_list_defines.svh */
// Assertion macros shared by the RTL
`ifndef CURSOR_DOUBLY_LINKED_LIST_DEFINES_SVH
`define CURSOR_DOUBLY_LINKED_LIST_DEFINES_SVH

// Same-cycle implication, checked out of reset
`define CDLL_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset
`define CDLL_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/cdll_pkg.sv */
package cdll_pkg;

    // Default pool size and sentinel item after reset
    localparam int NODE_COUNT_DEF = 256;
    localparam logic [31:0] DEFAULT_ITEM_RST = 32'hFFFF_FFFF;

    // Operation codes
    localparam logic [3:0] KIND_FIRST   = 4'd0;
    localparam logic [3:0] KIND_LAST    = 4'd1;
    localparam logic [3:0] KIND_NONE    = 4'd2;
    localparam logic [3:0] KIND_AFTER   = 4'd3;
    localparam logic [3:0] KIND_BEFORE  = 4'd4;
    localparam logic [3:0] KIND_GET     = 4'd5;
    localparam logic [3:0] KIND_SET     = 4'd6;
    localparam logic [3:0] KIND_INS_AFT = 4'd7;
    localparam logic [3:0] KIND_INS_BEF = 4'd8;
    localparam logic [3:0] KIND_DEL_AFT = 4'd9;
    localparam logic [3:0] KIND_DEL_BEF = 4'd10;

    // Link memory access request: one read or lane writes per cycle
    typedef struct packed {
        logic rd;
        logic wr_next;
        logic wr_back;
    } link_req_t;

endpackage

/* rtl/core/cdll_link_mem.sv */
module cdll_link_mem
    import cdll_pkg::*;
#(
    parameter int IDX_W = 9,
    parameter int DEPTH = 257
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  link_req_t        req,
    input  logic [IDX_W-1:0] addr,
    input  logic [IDX_W-1:0] wr_nxt,
    input  logic [IDX_W-1:0] wr_bck,
    output logic [IDX_W-1:0] rd_nxt,
    output logic [IDX_W-1:0] rd_bck
);

    // next link in the upper lane, back link in the lower lane
    logic [2*IDX_W-1:0] link_mem [DEPTH];
    logic [2*IDX_W-1:0] rd_reg;
    logic [IDX_W-1:0]   sent_nxt_reg;
    logic [IDX_W-1:0]   sent_bck_reg;
    logic               at_sent;

    assign at_sent = (addr == '0);

    // sentinel links live in flops so reset can make them self-pointing
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sent_nxt_reg <= '0;
            sent_bck_reg <= '0;
        end
        else if (at_sent)
        begin
            if (req.wr_next)
            begin
                sent_nxt_reg <= wr_nxt;
            end
            if (req.wr_back)
            begin
                sent_bck_reg <= wr_bck;
            end
        end
    end

    // pool entries: lane writes, registered read
    always_ff @(posedge clk)
    begin
        if (req.wr_next)
        begin
            link_mem[addr][2*IDX_W-1:IDX_W] <= wr_nxt;
        end
        if (req.wr_back)
        begin
            link_mem[addr][IDX_W-1:0] <= wr_bck;
        end
        if (req.rd)
        begin
            rd_reg <= at_sent ? {sent_nxt_reg, sent_bck_reg} : link_mem[addr];
        end
    end

    assign rd_nxt = rd_reg[2*IDX_W-1:IDX_W];
    assign rd_bck = rd_reg[IDX_W-1:0];

endmodule

/* rtl/core/cdll_item_mem.sv */
module cdll_item_mem
    import cdll_pkg::*;
#(
    parameter int IDX_W = 9,
    parameter int DEPTH = 257
)
(
    input  logic               clk,
    input  logic               en,
    input  logic               we,
    input  logic [IDX_W-1:0]   addr,
    input  logic signed [31:0] wdata,
    output logic signed [31:0] rdata
);

    logic signed [31:0] item_mem [DEPTH];
    logic signed [31:0] rd_reg;

    // single port; on a write the read register keeps its old value
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
            begin
                item_mem[addr] <= wdata;
            end
            else
            begin
                rd_reg <= item_mem[addr];
            end
        end
    end

    assign rdata = rd_reg;

endmodule

/* rtl/core/cursor_doubly_linked_list.sv */
// Channel  | Handshake                     | Payload
// ---------+-------------------------------+-----------------------------
// command  | start, busy (accept: !busy)   | kind, value
// result   | done (one-cycle strobe)       | item_out, ok, full_res
// config   | cfg_valid, cfg_ready          | default_item
//
// Steps: navigation, get, set, none, unused codes, a refused insert and a delete
// with nothing selected finish after the link read; delete then rewrites three
// link entries in turn; insert does too, after a free-chain read when the node comes off it.
// The order is set by the single-port link memory: one read or one write each
// cycle, and an insert or delete rewrites three entries.
// Reset clears the cursor, free chain, fresh count and sentinel links at once.
// No stall from the receiver: a result is shown for exactly one cycle.
module cursor_doubly_linked_list
    import cdll_pkg::*;
#(
    parameter int NODE_COUNT = NODE_COUNT_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [3:0]         kind,
    input  logic signed [31:0] value,
    output logic               busy,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic signed [31:0] default_item,
    output logic               done,
    output logic signed [31:0] item_out,
    output logic               ok,
    output logic               full_res
);

`include "cursor_doubly_linked_list_defines.svh"

    localparam int DEPTH = NODE_COUNT + 1;
    localparam int IDX_W = $clog2(DEPTH);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NODE_COUNT);

    typedef enum logic [8:0] {
        S_IDLE = 9'b000000001,
        S_LINK = 9'b000000010,
        S_FREE = 9'b000000100,
        S_W1   = 9'b000001000,
        S_W2   = 9'b000010000,
        S_W3   = 9'b000100000,
        S_D1   = 9'b001000000,
        S_D2   = 9'b010000000,
        S_D3   = 9'b100000000
    } state_t;

    state_t             state_reg, state_next;
    logic [3:0]         kind_reg, kind_next;
    logic signed [31:0] value_reg, value_next;
    logic [IDX_W-1:0]   cursor_reg, cursor_next;
    logic [IDX_W-1:0]   free_head_reg, free_head_next;
    logic [IDX_W-1:0]   fresh_reg, fresh_next;
    logic signed [31:0] default_reg;
    logic [IDX_W-1:0]   n_reg, n_next;
    logic [IDX_W-1:0]   p_reg, p_next;
    logic [IDX_W-1:0]   q_reg, q_next;
    logic               done_reg;
    logic signed [31:0] item_out_reg;
    logic               ok_reg;
    logic               full_reg;

    logic               fin;
    logic signed [31:0] res_item;
    logic               res_ok;
    logic               res_full;
    logic               sel;

    link_req_t          link_req;
    logic [IDX_W-1:0]   link_addr;
    logic [IDX_W-1:0]   link_wn;
    logic [IDX_W-1:0]   link_wb;
    logic [IDX_W-1:0]   link_rn;
    logic [IDX_W-1:0]   link_rb;

    logic               item_en;
    logic               item_we;
    logic [IDX_W-1:0]   item_addr;
    logic signed [31:0] item_rd;

    cdll_link_mem #(
        .IDX_W (IDX_W),
        .DEPTH (DEPTH)
    ) u_link (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (link_req),
        .addr   (link_addr),
        .wr_nxt (link_wn),
        .wr_bck (link_wb),
        .rd_nxt (link_rn),
        .rd_bck (link_rb)
    );

    cdll_item_mem #(
        .IDX_W (IDX_W),
        .DEPTH (DEPTH)
    ) u_item (
        .clk   (clk),
        .en    (item_en),
        .we    (item_we),
        .addr  (item_addr),
        .wdata (value_reg),
        .rdata (item_rd)
    );

    assign busy      = (state_reg != S_IDLE);
    assign cfg_ready = !busy;
    assign sel       = (cursor_reg != '0);

    // operation sequencer
    always_comb
    begin
        state_next     = state_reg;
        kind_next      = kind_reg;
        value_next     = value_reg;
        cursor_next    = cursor_reg;
        free_head_next = free_head_reg;
        fresh_next     = fresh_reg;
        n_next         = n_reg;
        p_next         = p_reg;
        q_next         = q_reg;
        fin            = 1'b0;
        res_item       = '0;
        res_ok         = 1'b0;
        res_full       = 1'b0;
        link_req       = '0;
        link_addr      = '0;
        link_wn        = '0;
        link_wb        = '0;
        item_en        = 1'b0;
        item_we        = 1'b0;
        item_addr      = cursor_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    kind_next   = kind;
                    value_next  = value;
                    link_req.rd = 1'b1;
                    link_addr   = (kind == KIND_FIRST || kind == KIND_LAST) ? '0 : cursor_reg;
                    item_en     = 1'b1;
                    state_next  = S_LINK;
                end
            end

            // links of the addressed node (and cursor item) are now valid
            S_LINK:
            begin
                case (kind_reg)
                    KIND_FIRST:
                    begin
                        cursor_next = link_rn;
                        fin = 1'b1;
                    end
                    KIND_LAST:
                    begin
                        cursor_next = link_rb;
                        fin = 1'b1;
                    end
                    KIND_NONE:
                    begin
                        res_ok = !sel;
                        fin = 1'b1;
                    end
                    KIND_AFTER:
                    begin
                        if (sel)
                        begin
                            cursor_next = link_rn;
                        end
                        res_ok = sel;
                        fin = 1'b1;
                    end
                    KIND_BEFORE:
                    begin
                        if (sel)
                        begin
                            cursor_next = link_rb;
                        end
                        res_ok = sel;
                        fin = 1'b1;
                    end
                    KIND_GET:
                    begin
                        res_item = sel ? item_rd : default_reg;
                        fin = 1'b1;
                    end
                    KIND_SET:
                    begin
                        item_en = sel;
                        item_we = sel;
                        res_ok  = sel;
                        fin = 1'b1;
                    end
                    KIND_INS_AFT, KIND_INS_BEF:
                    begin
                        p_next = (kind_reg == KIND_INS_AFT) ? cursor_reg : link_rb;
                        q_next = (kind_reg == KIND_INS_AFT) ? link_rn : cursor_reg;
                        if (free_head_reg != '0)
                        begin
                            // pop the free chain: need its next link
                            n_next      = free_head_reg;
                            link_req.rd = 1'b1;
                            link_addr   = free_head_reg;
                            state_next  = S_FREE;
                        end
                        else if (fresh_reg < LAST_IDX)
                        begin
                            n_next     = fresh_reg + 1'b1;
                            fresh_next = fresh_reg + 1'b1;
                            state_next = S_W1;
                        end
                        else
                        begin
                            res_full = 1'b1;
                            fin = 1'b1;
                        end
                    end
                    KIND_DEL_AFT, KIND_DEL_BEF:
                    begin
                        if (sel)
                        begin
                            p_next     = link_rb;
                            q_next     = link_rn;
                            state_next = S_D1;
                        end
                        else
                        begin
                            fin = 1'b1;
                        end
                    end
                    default:
                    begin
                        fin = 1'b1;
                    end
                endcase
            end

            S_FREE:
            begin
                free_head_next = link_rn;
                state_next     = S_W1;
            end

            // new node: both links and its item
            S_W1:
            begin
                link_req.wr_next = 1'b1;
                link_req.wr_back = 1'b1;
                link_addr        = n_reg;
                link_wn          = q_reg;
                link_wb          = p_reg;
                item_en          = 1'b1;
                item_we          = 1'b1;
                item_addr        = n_reg;
                state_next       = S_W2;
            end

            S_W2:
            begin
                link_req.wr_next = 1'b1;
                link_addr        = p_reg;
                link_wn          = n_reg;
                state_next       = S_W3;
            end

            S_W3:
            begin
                link_req.wr_back = 1'b1;
                link_addr        = q_reg;
                link_wb          = n_reg;
                cursor_next      = n_reg;
                fin = 1'b1;
            end

            // unlink: back neighbor's next, then next neighbor's back
            S_D1:
            begin
                link_req.wr_next = 1'b1;
                link_addr        = p_reg;
                link_wn          = q_reg;
                state_next       = S_D2;
            end

            S_D2:
            begin
                link_req.wr_back = 1'b1;
                link_addr        = q_reg;
                link_wb          = p_reg;
                state_next       = S_D3;
            end

            // push removed node onto the free chain
            S_D3:
            begin
                link_req.wr_next = 1'b1;
                link_addr        = cursor_reg;
                link_wn          = free_head_reg;
                free_head_next   = cursor_reg;
                cursor_next      = (kind_reg == KIND_DEL_AFT) ? q_reg : p_reg;
                res_ok           = 1'b1;
                fin = 1'b1;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (fin)
        begin
            state_next = S_IDLE;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cursor_reg    <= '0;
            free_head_reg <= '0;
            fresh_reg     <= '0;
            default_reg   <= DEFAULT_ITEM_RST;
            done_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cursor_reg    <= cursor_next;
            free_head_reg <= free_head_next;
            fresh_reg     <= fresh_next;
            done_reg      <= fin;
            if (cfg_valid && cfg_ready)
            begin
                default_reg <= default_item;
            end
        end
    end

    // operands and result payload
    always_ff @(posedge clk)
    begin
        kind_reg  <= kind_next;
        value_reg <= value_next;
        n_reg     <= n_next;
        p_reg     <= p_next;
        q_reg     <= q_next;
        if (fin)
        begin
            item_out_reg <= res_item;
            ok_reg       <= res_ok;
            full_reg     <= res_full;
        end
    end

    assign done     = done_reg;
    assign item_out = item_out_reg;
    assign ok       = ok_reg;
    assign full_res = full_reg;

    // checks
    `CDLL_ASSERT_NOW(a_done_idle, done_reg, state_reg == S_IDLE, "result strobe while busy")
    `CDLL_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted item did not start")
    `CDLL_ASSERT_NOW(a_fresh_range, 1'b1, fresh_reg <= LAST_IDX, "fresh count past pool size")
    `CDLL_ASSERT_NOW(a_cursor_range, 1'b1, cursor_reg <= fresh_reg, "cursor on a never-used node")
    `CDLL_ASSERT_NOW(a_full_only, done_reg && full_reg, !ok_reg && item_out_reg == '0,
        "full result carries other answers")
    `CDLL_ASSERT_NOW(a_link_port, link_req.rd, !link_req.wr_next && !link_req.wr_back,
        "link memory read and write in one cycle")

endmodule
